// ===== hw/rtl/bse_pkg.sv =====
// bse_pkg: segment kind codes, the tangent and acceleration width and the pipeline advance struct
// shared by the bezier segment evaluator modules
// no dependencies
package bse_pkg;

  // segment kinds
  localparam logic [1:0] MODE_LINE  = 2'd0;
  localparam logic [1:0] MODE_QUAD  = 2'd1;
  localparam logic [1:0] MODE_CUBIC = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // fixed width of the tangent and acceleration results
  localparam int DERIV_WIDTH = 32;

  // per-stage load enables, driven by the top level flow control
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } bse_adv_t;

endpackage

// ===== hw/rtl/bse_lane.sv =====
// bse_lane: one axis of the evaluator, a four-stage pipeline from control
// points to position, tangent and acceleration
// depends on bse_pkg
module bse_lane #(
  parameter int W = 24,
  parameter int T = 16
) (
  input  logic                               clk,
  input  bse_pkg::bse_adv_t                  adv,
  input  logic [1:0]                         mode,
  input  logic signed [W-1:0]                p0,
  input  logic signed [W-1:0]                p1,
  input  logic signed [W-1:0]                p2,
  input  logic signed [W-1:0]                p3,
  input  logic [T:0]                         t,
  output logic signed [W-1:0]                pos,
  output logic signed [bse_pkg::DERIV_WIDTH-1:0] tan,
  output logic signed [bse_pkg::DERIV_WIDTH-1:0] acc
);
  import bse_pkg::*;

  // internal width holds every intermediate exactly (all stay below 2^(W+7))
  localparam int IW  = W + 8;
  localparam int TW  = T + 2;
  localparam int PW  = IW + TW;
  localparam int PW3 = PW + 3;

  // stage 1: power-basis coefficients
  logic signed [IW-1:0] e0, e1, e2, e3, d10, d12, s2nd;
  logic signed [IW-1:0] c1_nxt, c2_nxt, c3_nxt;
  logic signed [TW-1:0] t_nxt;
  logic signed [IW-1:0] c0_s1_r, c1_s1_r, c2_s1_r, c3_s1_r;
  logic signed [TW-1:0] t_s1_r;

  assign e0    = IW'(p0);
  assign e1    = IW'(p1);
  assign e2    = IW'(p2);
  assign e3    = IW'(p3);
  assign d10   = e1 - e0;
  assign d12   = e1 - e2;
  assign s2nd  = e0 - (e1 <<< 1) + e2;
  assign t_nxt = $signed({1'b0, t});

  always_comb begin
    c1_nxt = '0;
    c2_nxt = '0;
    c3_nxt = '0;
    case (mode)
      MODE_LINE: begin
        c1_nxt = d10;
      end
      MODE_QUAD: begin
        c1_nxt = d10 <<< 1;
        c2_nxt = s2nd;
      end
      default: begin
        c1_nxt = d10 + (d10 <<< 1);
        c2_nxt = s2nd + (s2nd <<< 1);
        c3_nxt = e3 - e0 + d12 + (d12 <<< 1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      c0_s1_r <= e0;
      c1_s1_r <= c1_nxt;
      c2_s1_r <= c2_nxt;
      c3_s1_r <= c3_nxt;
      t_s1_r  <= t_nxt;
    end
  end

  // stage 2: one product c3*t serves the 1x, 3x and 6x terms
  logic signed [PW-1:0]  m2_prod;
  logic signed [PW3-1:0] m2_x1, m2_x3, m2_x6;
  logic signed [IW-1:0]  pa_nxt, ta_nxt, acc2_nxt;
  logic signed [IW-1:0]  pa_s2_r, ta_s2_r, acc_s2_r, c0_s2_r, c1_s2_r;
  logic signed [TW-1:0]  t_s2_r;

  assign m2_prod  = c3_s1_r * t_s1_r;
  assign m2_x1    = PW3'(m2_prod);
  assign m2_x3    = m2_x1 + (m2_x1 <<< 1);
  assign m2_x6    = m2_x3 <<< 1;
  assign pa_nxt   = IW'(m2_x1 >>> T) + c2_s1_r;
  assign ta_nxt   = IW'(m2_x3 >>> T) + (c2_s1_r <<< 1);
  assign acc2_nxt = IW'(m2_x6 >>> T) + (c2_s1_r <<< 1);

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      pa_s2_r  <= pa_nxt;
      ta_s2_r  <= ta_nxt;
      acc_s2_r <= acc2_nxt;
      c0_s2_r  <= c0_s1_r;
      c1_s2_r  <= c1_s1_r;
      t_s2_r   <= t_s1_r;
    end
  end

  // stage 3: second horner step for position, last one for tangent
  logic signed [PW-1:0] m3_pos, m3_tan;
  logic signed [IW-1:0] pb_nxt, tan3_nxt;
  logic signed [IW-1:0] pb_s3_r, tan_s3_r, acc_s3_r, c0_s3_r;
  logic signed [TW-1:0] t_s3_r;

  assign m3_pos   = pa_s2_r * t_s2_r;
  assign m3_tan   = ta_s2_r * t_s2_r;
  assign pb_nxt   = IW'(m3_pos >>> T) + c1_s2_r;
  assign tan3_nxt = IW'(m3_tan >>> T) + c1_s2_r;

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      pb_s3_r  <= pb_nxt;
      tan_s3_r <= tan3_nxt;
      acc_s3_r <= acc_s2_r;
      c0_s3_r  <= c0_s2_r;
      t_s3_r   <= t_s2_r;
    end
  end

  // stage 4: last horner step for position
  logic signed [PW-1:0] m4_pos;
  logic signed [IW-1:0] pos4_nxt;
  logic signed [IW-1:0] pos_s4_r, tan_s4_r, acc_s4_r;

  assign m4_pos   = pb_s3_r * t_s3_r;
  assign pos4_nxt = IW'(m4_pos >>> T) + c0_s3_r;

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      pos_s4_r <= pos4_nxt;
      tan_s4_r <= tan_s3_r;
      acc_s4_r <= acc_s3_r;
    end
  end

  // results wrap to their field widths
  assign pos = pos_s4_r[W-1:0];
  assign tan = DERIV_WIDTH'(tan_s4_r);
  assign acc = DERIV_WIDTH'(acc_s4_r);

endmodule

// ===== hw/rtl/bse_merge.sv =====
// bse_merge: output register that joins the x and y lanes, sets valid_res
// and zeroes the result of an unsupported kind
// depends on bse_pkg
module bse_merge #(
  parameter int W = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_vld,
  input  logic [1:0]                             in_mode,
  input  logic signed [W-1:0]                    x_pos,
  input  logic signed [W-1:0]                    y_pos,
  input  logic signed [bse_pkg::DERIV_WIDTH-1:0] x_tan,
  input  logic signed [bse_pkg::DERIV_WIDTH-1:0] y_tan,
  input  logic signed [bse_pkg::DERIV_WIDTH-1:0] x_acc,
  input  logic signed [bse_pkg::DERIV_WIDTH-1:0] y_acc,
  output logic                                   take,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [W-1:0]                    out_pos_x,
  output logic signed [W-1:0]                    out_pos_y,
  output logic signed [bse_pkg::DERIV_WIDTH-1:0] out_tangent_x,
  output logic signed [bse_pkg::DERIV_WIDTH-1:0] out_tangent_y,
  output logic signed [bse_pkg::DERIV_WIDTH-1:0] out_accel_x,
  output logic signed [bse_pkg::DERIV_WIDTH-1:0] out_accel_y,
  output logic                                   out_valid_res
);
  import bse_pkg::*;

  logic out_valid_r;
  logic ok;

  assign take = !out_valid_r || !out_stall;
  assign ok   = (in_mode != MODE_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_pos_x     <= ok ? x_pos : '0;
      out_pos_y     <= ok ? y_pos : '0;
      out_tangent_x <= ok ? x_tan : '0;
      out_tangent_y <= ok ? y_tan : '0;
      out_accel_x   <= ok ? x_acc : '0;
      out_accel_y   <= ok ? y_acc : '0;
      out_valid_res <= ok;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/bezier_segment_evaluator.sv =====
// bezier_segment_evaluator: top level, flow control, mode pipeline, two axis
// lanes and the merging output stage
// depends on bse_pkg, bse_lane, bse_merge
//
// Evaluates one line, quadratic or cubic bezier segment per request: the
// control points are turned into power-basis coefficients per axis and the
// position, tangent and acceleration at t are found by horner's rule, each
// product with t truncated toward minus infinity. The x and y axes run in
// two identical lanes side by side and an output stage joins them, sets
// valid_res and returns all zeros for the unsupported kind. One request is
// taken every cycle while in_stall is low; a request passes through the
// coefficient stage, the three dependent multiplies of the position path
// (one pipeline stage each) and the output register. Every request gives
// exactly one result, in order. A stall on the output holds the output
// register; the inner stages keep filling bubbles and stall the input only
// once every stage holds a result.
module bezier_segment_evaluator #(
  parameter int COORD_WIDTH = 24,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_mode,
  input  logic signed [COORD_WIDTH-1:0]          in_p0_x,
  input  logic signed [COORD_WIDTH-1:0]          in_p0_y,
  input  logic signed [COORD_WIDTH-1:0]          in_p1_x,
  input  logic signed [COORD_WIDTH-1:0]          in_p1_y,
  input  logic signed [COORD_WIDTH-1:0]          in_p2_x,
  input  logic signed [COORD_WIDTH-1:0]          in_p2_y,
  input  logic signed [COORD_WIDTH-1:0]          in_p3_x,
  input  logic signed [COORD_WIDTH-1:0]          in_p3_y,
  input  logic [T_FRAC_BITS:0]                   in_t_param,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [COORD_WIDTH-1:0]          out_pos_x,
  output logic signed [COORD_WIDTH-1:0]          out_pos_y,
  output logic signed [bse_pkg::DERIV_WIDTH-1:0] out_tangent_x,
  output logic signed [bse_pkg::DERIV_WIDTH-1:0] out_tangent_y,
  output logic signed [bse_pkg::DERIV_WIDTH-1:0] out_accel_x,
  output logic signed [bse_pkg::DERIV_WIDTH-1:0] out_accel_y,
  output logic                                   out_valid_res
);
  import bse_pkg::*;

  // stage occupancy
  logic vld_s1_r, vld_s2_r, vld_s3_r, vld_s4_r;
  // segment kind follows its request down the pipe
  logic [1:0] mode_s1_r, mode_s2_r, mode_s3_r, mode_s4_r;

  logic     take;
  logic     rdy1, rdy2, rdy3, rdy4;
  bse_adv_t adv;

  // a stage loads when it is empty or its contents move on
  assign rdy4 = !vld_s4_r || take;
  assign rdy3 = !vld_s3_r || rdy4;
  assign rdy2 = !vld_s2_r || rdy3;
  assign rdy1 = !vld_s1_r || rdy2;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;
  assign adv.s4 = rdy4;

  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_s1_r <= 1'b0;
      vld_s2_r <= 1'b0;
      vld_s3_r <= 1'b0;
      vld_s4_r <= 1'b0;
    end else begin
      if (rdy1) vld_s1_r <= in_valid;
      if (rdy2) vld_s2_r <= vld_s1_r;
      if (rdy3) vld_s3_r <= vld_s2_r;
      if (rdy4) vld_s4_r <= vld_s3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) mode_s1_r <= in_mode;
    if (rdy2) mode_s2_r <= mode_s1_r;
    if (rdy3) mode_s3_r <= mode_s2_r;
    if (rdy4) mode_s4_r <= mode_s3_r;
  end

  // lane results
  logic signed [COORD_WIDTH-1:0] x_pos, y_pos;
  logic signed [DERIV_WIDTH-1:0] x_tan, y_tan, x_acc, y_acc;

  // x axis lane
  bse_lane #(
    .W (COORD_WIDTH),
    .T (T_FRAC_BITS)
  ) u_lane_x (
    .clk  (clk),
    .adv  (adv),
    .mode (in_mode),
    .p0   (in_p0_x),
    .p1   (in_p1_x),
    .p2   (in_p2_x),
    .p3   (in_p3_x),
    .t    (in_t_param),
    .pos  (x_pos),
    .tan  (x_tan),
    .acc  (x_acc)
  );

  // y axis lane
  bse_lane #(
    .W (COORD_WIDTH),
    .T (T_FRAC_BITS)
  ) u_lane_y (
    .clk  (clk),
    .adv  (adv),
    .mode (in_mode),
    .p0   (in_p0_y),
    .p1   (in_p1_y),
    .p2   (in_p2_y),
    .p3   (in_p3_y),
    .t    (in_t_param),
    .pos  (y_pos),
    .tan  (y_tan),
    .acc  (y_acc)
  );

  // join the lanes into the output register
  bse_merge #(
    .W (COORD_WIDTH)
  ) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (vld_s4_r),
    .in_mode       (mode_s4_r),
    .x_pos         (x_pos),
    .y_pos         (y_pos),
    .x_tan         (x_tan),
    .y_tan         (y_tan),
    .x_acc         (x_acc),
    .y_acc         (y_acc),
    .take          (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_tangent_x (out_tangent_x),
    .out_tangent_y (out_tangent_y),
    .out_accel_x   (out_accel_x),
    .out_accel_y   (out_accel_y),
    .out_valid_res (out_valid_res)
  );

`ifndef SYNTHESIS
  // an accepted request always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_s1_r)
    else $error("accepted request lost at stage 1");

  // a finished result waits in stage 4 while the output register is held
  a_s4_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vld_s4_r && !take |=> vld_s4_r)
    else $error("stage 4 result dropped while output held");

  // an unsupported kind leaves all-zero fields
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_pos_x == '0 && out_pos_y == '0 &&
      out_tangent_x == '0 && out_tangent_y == '0 &&
      out_accel_x == '0 && out_accel_y == '0)
    else $error("unsupported kind gave nonzero result");

  // a line has no acceleration
  a_line_accel: assert property (@(posedge clk) disable iff (!rst_n)
    vld_s4_r && mode_s4_r == MODE_LINE |-> x_acc == '0 && y_acc == '0)
    else $error("line segment with nonzero acceleration");
`endif

endmodule
